// ----- src/mll_pkg.sv -----
`default_nettype none

package mll_pkg;

    localparam int CATEGORIES     = 4;
    localparam int DEF_COUNT_BITS = 12;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int LP_BITS        = 32;
    localparam int OUT_BITS       = 48;
    localparam int CFG_INDEX_BITS = 3;

    // log2 mantissa refinement: one squaring per fraction bit
    localparam int LOG_FRAC_STEPS = 30;
    localparam int MANT_BITS      = 31;

    // ln 2 in Q.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef logic signed [LP_BITS-1:0]  lp_t;
    typedef logic signed [OUT_BITS-1:0] out_t;

    localparam lp_t  LP_ZERO_PROB = {1'b1, {(LP_BITS-1){1'b0}}};
    localparam out_t OUT_MIN      = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam out_t OUT_MAX      = {1'b0, {(OUT_BITS-1){1'b1}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LOG_PROB_FIRST   = 3'd0,
        CFG_LOG_PROB_SECOND  = 3'd1,
        CFG_LOG_PROB_THIRD   = 3'd2,
        CFG_LOG_PROB_FOURTH  = 3'd3,
        CFG_WITH_COEFFICIENT = 3'd4
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- src/multinomial_log_likelihood_unit.sv -----
`default_nettype none

// four-category multinomial log-likelihood, signed fixed point with FRAC_BITS fraction bits
// config: write log_prob_first..fourth (indexes 0..3) and with_coefficient (index 4)
//   through cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high
// items: drive the four counts with start high; an item is taken when start is high
//   and busy is low
// results: done is high for one cycle with log_likelihood and impossible; the receiver
//   cannot hold a result off
// an item goes through products and table reads, pair sums, stages 3 and 4, output stage
// throughput: one item per cycle while busy is low, set by the five-stage datapath and
//   the three log-factorial tables read in parallel (one single-port, two dual-port reads)
// reset: the log-prob registers go to 0 and with_coefficient to 1; busy then stays high
//   while the log-factorial table is built, one entry per cycle through a 30-stage log2
//   pipe, for all CATEGORIES*(2^COUNT_BITS-1)+1 entries (16381 at 12-bit counts)
// a zero-probability category with a nonzero count gives the minimum result and
//   raises impossible

module multinomial_log_likelihood_unit #(
    parameter int COUNT_BITS = mll_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = mll_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [COUNT_BITS-1:0]                 count_first,
    input  wire logic [COUNT_BITS-1:0]                 count_second,
    input  wire logic [COUNT_BITS-1:0]                 count_third,
    input  wire logic [COUNT_BITS-1:0]                 count_fourth,
    output logic                                       done,
    output logic signed [mll_pkg::OUT_BITS-1:0]        log_likelihood,
    output logic                                       impossible,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mll_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [mll_pkg::LP_BITS-1:0]           cfg_data
);

    localparam int ENTRIES  = mll_pkg::CATEGORIES * ((1 << COUNT_BITS) - 1) + 1;
    localparam int IDX_BITS = $clog2(ENTRIES);
    localparam int E_BITS   = $clog2(IDX_BITS);
    localparam int LF_BITS  = IDX_BITS + E_BITS + FRAC_BITS;

    mll_pkg::lp_t           log_prob_reg [mll_pkg::CATEGORIES];
    logic                   with_coef_reg;
    logic                   accept;
    logic                   fill_done;

    logic                   wr_valid;
    logic [IDX_BITS-1:0]    wr_addr;
    logic [LF_BITS-1:0]     wr_data;
    logic [IDX_BITS-1:0]    rd_total_addr;
    logic [COUNT_BITS-1:0]  rd_count_addr [mll_pkg::CATEGORIES];
    logic [LF_BITS-1:0]     rd_total_data;
    logic [LF_BITS-1:0]     rd_count_data [mll_pkg::CATEGORIES];
    logic [COUNT_BITS-1:0]  count [mll_pkg::CATEGORIES];

    assign cfg_ready = 1'b1;
    assign busy      = !fill_done;
    assign accept    = start && !busy;

    assign count[0] = count_first;
    assign count[1] = count_second;
    assign count[2] = count_third;
    assign count[3] = count_fourth;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mll_pkg::CATEGORIES; i++)
            begin
                log_prob_reg[i] <= '0;
            end
            with_coef_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mll_pkg::cfg_reg_t'(cfg_index))
                mll_pkg::CFG_LOG_PROB_FIRST:   log_prob_reg[0] <= cfg_data;
                mll_pkg::CFG_LOG_PROB_SECOND:  log_prob_reg[1] <= cfg_data;
                mll_pkg::CFG_LOG_PROB_THIRD:   log_prob_reg[2] <= cfg_data;
                mll_pkg::CFG_LOG_PROB_FOURTH:  log_prob_reg[3] <= cfg_data;
                mll_pkg::CFG_WITH_COEFFICIENT: with_coef_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mll_lnfact_fill #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_valid  (wr_valid),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .fill_done (fill_done)
    );

    mll_lnfact_mem #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mem (
        .clk           (clk),
        .wr_valid      (wr_valid),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_total_addr (rd_total_addr),
        .rd_count_addr (rd_count_addr),
        .rd_total_data (rd_total_data),
        .rd_count_data (rd_count_data)
    );

    mll_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (accept),
        .count            (count),
        .log_prob         (log_prob_reg),
        .with_coefficient (with_coef_reg),
        .rd_total_addr    (rd_total_addr),
        .rd_count_addr    (rd_count_addr),
        .rd_total_data    (rd_total_data),
        .rd_count_data    (rd_count_data),
        .out_valid        (done),
        .out_value        (log_likelihood),
        .out_impossible   (impossible)
    );

    item_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done
    ) else $error("accepted item gave no result after five cycles");

    impossible_is_minimum: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && impossible) |-> log_likelihood == mll_pkg::OUT_MIN
    ) else $error("impossible item without minimum result");

    no_result_during_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> !busy
    ) else $error("result while table fill in progress");

endmodule

`default_nettype wire

// ----- src/mll_lnfact_fill.sv -----
`default_nettype none

module mll_lnfact_fill #(
    parameter int COUNT_BITS = mll_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = mll_pkg::DEF_FRAC_BITS,
    localparam int ENTRIES   = mll_pkg::CATEGORIES * ((1 << COUNT_BITS) - 1) + 1,
    localparam int IDX_BITS  = $clog2(ENTRIES),
    localparam int E_BITS    = $clog2(IDX_BITS),
    localparam int LF_BITS   = IDX_BITS + E_BITS + FRAC_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    output logic                     wr_valid,
    output logic [IDX_BITS-1:0]      wr_addr,
    output logic [LF_BITS-1:0]       wr_data,
    output logic                     fill_done
);

    localparam int STEPS    = mll_pkg::LOG_FRAC_STEPS;
    localparam int MB       = mll_pkg::MANT_BITS;
    localparam int SHIFT_W  = IDX_BITS + MB - 1;
    localparam int LN_BITS  = 32 + E_BITS;
    localparam int ACC_BITS = LF_BITS - FRAC_BITS + 32;
    localparam int FP_BITS  = STEPS + 32;
    localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(ENTRIES - 1);
    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (31 - FRAC_BITS);

    // issue counter
    logic                 issue_reg, issue_next;
    logic [IDX_BITS-1:0]  k_reg, k_next;
    logic [E_BITS-1:0]    e_reg, e_next;
    logic [IDX_BITS:0]    pow_reg, pow_next;
    logic [E_BITS-1:0]    e_cur;
    logic [SHIFT_W-1:0]   k_shift;
    logic [MB-1:0]        m_first;

    // squaring stages
    logic                 sq_v_reg [0:STEPS];
    logic [IDX_BITS-1:0]  sq_k_reg [0:STEPS];
    logic [E_BITS-1:0]    sq_e_reg [0:STEPS];
    logic [MB-1:0]        sq_m_reg [0:STEPS];
    logic [STEPS-1:0]     sq_f_reg [0:STEPS];
    logic [MB:0]          sq_t     [1:STEPS];
    logic [MB-1:0]        sq_m_next [1:STEPS];
    logic [STEPS-1:0]     sq_f_next [1:STEPS];

    // product, ln and accumulate stages
    logic                 p_v_reg, l_v_reg, a_v_reg;
    logic [IDX_BITS-1:0]  p_k_reg, l_k_reg, a_k_reg;
    logic [LN_BITS-1:0]   p_eterm_reg, l_ln_reg;
    logic [FP_BITS-1:0]   p_fprod_reg;
    logic [ACC_BITS-1:0]  acc_reg, acc_next;

    logic                 wr_valid_reg;
    logic [IDX_BITS-1:0]  wr_addr_reg;
    logic [LF_BITS-1:0]   wr_data_reg;
    logic                 fill_done_reg, fill_done_next;

    always_comb
    begin
        e_cur   = ({1'b0, k_reg} == pow_reg) ? E_BITS'(e_reg + 1'b1) : e_reg;
        k_shift = {k_reg, {(MB-1){1'b0}}} >> e_cur;
        m_first = k_shift[MB-1:0];
    end

    always_comb
    begin
        issue_next = issue_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        pow_next   = pow_reg;
        if (issue_reg)
        begin
            k_next = IDX_BITS'(k_reg + 1'b1);
            e_next = e_cur;
            if ({1'b0, k_reg} == pow_reg)
            begin
                pow_next = {pow_reg[IDX_BITS-1:0], 1'b0};
            end
            if (k_reg == LAST)
            begin
                issue_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b1;
            k_reg     <= '0;
            e_reg     <= '0;
            pow_reg   <= (IDX_BITS+1)'(2);
        end
        else
        begin
            issue_reg <= issue_next;
            k_reg     <= k_next;
            e_reg     <= e_next;
            pow_reg   <= pow_next;
        end
    end

    // one squaring of the q.30 mantissa per stage, one fraction bit each
    always_comb
    begin
        for (int i = 1; i <= STEPS; i++)
        begin
            sq_t[i] = (MB+1)'(({{MB{1'b0}}, sq_m_reg[i-1]} * {{MB{1'b0}}, sq_m_reg[i-1]})
                              >> (MB - 1));
            sq_m_next[i] = sq_t[i][MB] ? sq_t[i][MB:1] : sq_t[i][MB-1:0];
            sq_f_next[i] = sq_f_reg[i-1];
            sq_f_next[i][STEPS-i] = sq_t[i][MB];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                sq_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            sq_v_reg[0] <= issue_reg;
            for (int i = 1; i <= STEPS; i++)
            begin
                sq_v_reg[i] <= sq_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sq_k_reg[0] <= k_reg;
        sq_e_reg[0] <= e_cur;
        sq_m_reg[0] <= m_first;
        sq_f_reg[0] <= '0;
        for (int i = 1; i <= STEPS; i++)
        begin
            sq_k_reg[i] <= sq_k_reg[i-1];
            sq_e_reg[i] <= sq_e_reg[i-1];
            sq_m_reg[i] <= sq_m_next[i];
            sq_f_reg[i] <= sq_f_next[i];
        end
    end

    always_comb
    begin
        acc_next       = l_v_reg ? ACC_BITS'(acc_reg + ACC_BITS'(l_ln_reg)) : acc_reg;
        fill_done_next = fill_done_reg || (wr_valid_reg && wr_addr_reg == LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg       <= 1'b0;
            l_v_reg       <= 1'b0;
            a_v_reg       <= 1'b0;
            wr_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            fill_done_reg <= 1'b0;
        end
        else
        begin
            p_v_reg       <= sq_v_reg[STEPS];
            l_v_reg       <= p_v_reg;
            a_v_reg       <= l_v_reg;
            wr_valid_reg  <= a_v_reg;
            acc_reg       <= acc_next;
            fill_done_reg <= fill_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_k_reg     <= sq_k_reg[STEPS];
        p_eterm_reg <= LN_BITS'(sq_e_reg[STEPS]) * LN_BITS'(mll_pkg::LN2_Q32);
        p_fprod_reg <= FP_BITS'(sq_f_reg[STEPS]) * FP_BITS'(mll_pkg::LN2_Q32);
        l_k_reg     <= p_k_reg;
        l_ln_reg    <= LN_BITS'(p_eterm_reg + LN_BITS'(p_fprod_reg[FP_BITS-1:STEPS]));
        a_k_reg     <= l_k_reg;
        wr_addr_reg <= a_k_reg;
        wr_data_reg <= LF_BITS'(ACC_BITS'(acc_reg + HALF) >> (32 - FRAC_BITS));
    end

    assign wr_valid  = wr_valid_reg;
    assign wr_addr   = wr_addr_reg;
    assign wr_data   = wr_data_reg;
    assign fill_done = fill_done_reg;

    no_write_after_fill: assert property (
        @(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> !fill_done_reg
    ) else $error("table write after fill finished");

    fill_ends_on_last_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(fill_done_reg) |-> $past(wr_valid_reg) && $past(wr_addr_reg) == LAST
    ) else $error("fill finished before the last entry");

endmodule

`default_nettype wire

// ----- src/mll_lnfact_mem.sv -----
`default_nettype none

module mll_lnfact_mem #(
    parameter int COUNT_BITS = mll_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = mll_pkg::DEF_FRAC_BITS,
    localparam int ENTRIES   = mll_pkg::CATEGORIES * ((1 << COUNT_BITS) - 1) + 1,
    localparam int IDX_BITS  = $clog2(ENTRIES),
    localparam int E_BITS    = $clog2(IDX_BITS),
    localparam int LF_BITS   = IDX_BITS + E_BITS + FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   wr_valid,
    input  wire logic [IDX_BITS-1:0]    wr_addr,
    input  wire logic [LF_BITS-1:0]     wr_data,
    input  wire logic [IDX_BITS-1:0]    rd_total_addr,
    input  wire logic [COUNT_BITS-1:0]  rd_count_addr [mll_pkg::CATEGORIES],
    output logic      [LF_BITS-1:0]     rd_total_data,
    output logic      [LF_BITS-1:0]     rd_count_data [mll_pkg::CATEGORIES]
);

    localparam int CNT_ENTRIES = 1 << COUNT_BITS;

    // full table for the total, two low copies for the per-category counts
    logic [LF_BITS-1:0] tot_mem    [0:ENTRIES-1];
    logic [LF_BITS-1:0] cnt_lo_mem [0:CNT_ENTRIES-1];
    logic [LF_BITS-1:0] cnt_hi_mem [0:CNT_ENTRIES-1];
    logic               wr_low;

    assign wr_low = (wr_addr[IDX_BITS-1:COUNT_BITS] == '0);

    always_ff @(posedge clk)
    begin
        if (wr_valid)
        begin
            tot_mem[wr_addr] <= wr_data;
        end
        rd_total_data <= tot_mem[rd_total_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_low)
        begin
            cnt_lo_mem[wr_addr[COUNT_BITS-1:0]] <= wr_data;
        end
        rd_count_data[0] <= cnt_lo_mem[rd_count_addr[0]];
        rd_count_data[1] <= cnt_lo_mem[rd_count_addr[1]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_low)
        begin
            cnt_hi_mem[wr_addr[COUNT_BITS-1:0]] <= wr_data;
        end
        rd_count_data[2] <= cnt_hi_mem[rd_count_addr[2]];
        rd_count_data[3] <= cnt_hi_mem[rd_count_addr[3]];
    end

endmodule

`default_nettype wire

// ----- src/mll_datapath.sv -----
`default_nettype none

module mll_datapath #(
    parameter int COUNT_BITS = mll_pkg::DEF_COUNT_BITS,
    parameter int FRAC_BITS  = mll_pkg::DEF_FRAC_BITS,
    localparam int ENTRIES   = mll_pkg::CATEGORIES * ((1 << COUNT_BITS) - 1) + 1,
    localparam int IDX_BITS  = $clog2(ENTRIES),
    localparam int E_BITS    = $clog2(IDX_BITS),
    localparam int LF_BITS   = IDX_BITS + E_BITS + FRAC_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [COUNT_BITS-1:0]  count [mll_pkg::CATEGORIES],
    input  wire mll_pkg::lp_t           log_prob [mll_pkg::CATEGORIES],
    input  wire logic                   with_coefficient,
    output logic      [IDX_BITS-1:0]    rd_total_addr,
    output logic      [COUNT_BITS-1:0]  rd_count_addr [mll_pkg::CATEGORIES],
    input  wire logic [LF_BITS-1:0]     rd_total_data,
    input  wire logic [LF_BITS-1:0]     rd_count_data [mll_pkg::CATEGORIES],
    output logic                        out_valid,
    output mll_pkg::out_t               out_value,
    output logic                        out_impossible
);

    localparam int OB     = mll_pkg::OUT_BITS;
    localparam int PROD_W = COUNT_BITS + 1 + mll_pkg::LP_BITS;
    localparam int DOT_W  = PROD_W + 2;
    localparam int LFS_W  = LF_BITS + 3;
    localparam int MAX_A  = (DOT_W > LFS_W) ? DOT_W : LFS_W;
    localparam int SUM_W  = ((MAX_A > OB) ? MAX_A : OB) + 1;

    // stage 1: products and table reads
    logic                       v1_reg;
    logic signed [PROD_W-1:0]   p_reg  [mll_pkg::CATEGORIES];
    logic signed [PROD_W-1:0]   p_next [mll_pkg::CATEGORIES];
    logic                       imp1_reg, imp1_next;
    logic                       mode1_reg;

    // stage 2: pair sums
    logic                       v2_reg, imp2_reg, mode2_reg;
    logic signed [DOT_W-1:0]    d01_reg, d23_reg;
    logic signed [LFS_W-1:0]    ca2_reg, cb2_reg, c3_reg;
    logic signed [LFS_W-1:0]    lf_tot, lf_c [mll_pkg::CATEGORIES];

    // stage 3
    logic                       v3_reg, imp3_reg, mode3_reg;
    logic signed [DOT_W-1:0]    dot3_reg;
    logic signed [LFS_W-1:0]    ca3_reg, cc3_reg;

    // stage 4
    logic                       v4_reg, imp4_reg, mode4_reg;
    logic signed [DOT_W-1:0]    dot4_reg;
    logic signed [LFS_W-1:0]    coef4_reg;

    // output stage
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-OB:0]          sum_top;
    mll_pkg::out_t              value_next;
    logic                       out_valid_reg;
    mll_pkg::out_t              out_value_reg;
    logic                       out_impossible_reg;

    always_comb
    begin
        rd_total_addr = IDX_BITS'(count[0]) + IDX_BITS'(count[1])
                      + IDX_BITS'(count[2]) + IDX_BITS'(count[3]);
        imp1_next = 1'b0;
        for (int i = 0; i < mll_pkg::CATEGORIES; i++)
        begin
            rd_count_addr[i] = count[i];
            p_next[i] = PROD_W'($signed({1'b0, count[i]})) * PROD_W'(log_prob[i]);
            if (log_prob[i] == mll_pkg::LP_ZERO_PROB && count[i] != '0)
            begin
                imp1_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        lf_tot = $signed({3'b000, rd_total_data});
        for (int i = 0; i < mll_pkg::CATEGORIES; i++)
        begin
            lf_c[i] = $signed({3'b000, rd_count_data[i]});
        end
    end

    always_comb
    begin
        sum_next = SUM_W'(dot4_reg) + (mode4_reg ? SUM_W'(coef4_reg) : SUM_W'(0));
        sum_top  = sum_next[SUM_W-1:OB-1];
        if (imp4_reg)
        begin
            value_next = mll_pkg::OUT_MIN;
        end
        else if (sum_top == '0 || sum_top == '1)
        begin
            value_next = sum_next[OB-1:0];
        end
        else if (sum_next[SUM_W-1])
        begin
            value_next = mll_pkg::OUT_MIN;
        end
        else
        begin
            value_next = mll_pkg::OUT_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mll_pkg::CATEGORIES; i++)
        begin
            p_reg[i] <= p_next[i];
        end
        imp1_reg  <= imp1_next;
        mode1_reg <= with_coefficient;

        d01_reg   <= DOT_W'(p_reg[0]) + DOT_W'(p_reg[1]);
        d23_reg   <= DOT_W'(p_reg[2]) + DOT_W'(p_reg[3]);
        ca2_reg   <= lf_tot - lf_c[0];
        cb2_reg   <= lf_c[1] + lf_c[2];
        c3_reg    <= lf_c[3];
        imp2_reg  <= imp1_reg;
        mode2_reg <= mode1_reg;

        dot3_reg  <= d01_reg + d23_reg;
        ca3_reg   <= ca2_reg;
        cc3_reg   <= cb2_reg + c3_reg;
        imp3_reg  <= imp2_reg;
        mode3_reg <= mode2_reg;

        dot4_reg  <= dot3_reg;
        coef4_reg <= ca3_reg - cc3_reg;
        imp4_reg  <= imp3_reg;
        mode4_reg <= mode3_reg;

        out_value_reg      <= value_next;
        out_impossible_reg <= imp4_reg;
    end

    assign out_valid      = out_valid_reg;
    assign out_value      = out_value_reg;
    assign out_impossible = out_impossible_reg;

endmodule

`default_nettype wire
